@@ design/iplu_pkg.sv @@
// Shared types, codes and helpers for the IPv4 prefix rule lookup unit.
// No dependencies; every other file in this block imports this package.
`timescale 1ns / 1ps

package iplu_pkg;

  localparam int ADDR_W         = 32;
  localparam int PLEN_W         = 6;
  localparam int ACT_W          = 2;
  localparam int TAG_W          = 16;
  localparam int RULE_DEPTH_DEF = 256;

  typedef enum logic [1:0] {
    KIND_INSERT    = 2'd0,
    KIND_LOOKUP    = 2'd1,
    KIND_CLEAR_ALL = 2'd2,
    KIND_CLEAR_GEO = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_DUP      = 2'd1,
    STAT_CONFLICT = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  address;
    logic [PLEN_W-1:0]  prefix_len;
    logic [ACT_W-1:0]   rule_action;
    logic               from_geo;
    logic [TAG_W-1:0]   tag;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic               matched;
    logic [ACT_W-1:0]   action_out;
    logic               match_geo;
    logic [TAG_W-1:0]   match_tag;
  } out_res_t;

  // One stored rule: 57 bits.
  typedef struct packed {
    logic [ADDR_W-1:0]  net;
    logic [PLEN_W-1:0]  plen;
    logic [ACT_W-1:0]   act;
    logic               geo;
    logic [TAG_W-1:0]   tag;
  } rule_t;

  // Sequencer controls toward the datapath.
  typedef struct packed {
    logic busy;
    logic clr;
    logic issue;
    logic step;
    logic finish;
  } ctl_t;

  // Running summary of a scan.
  typedef struct packed {
    logic               hit_found;
    logic [ACT_W-1:0]   hit_act;
    logic               hit_geo;
    logic [TAG_W-1:0]   hit_tag;
    logic               dup_found;
    logic [ACT_W-1:0]   dup_act;
    logic [TAG_W-1:0]   dup_tag;
  } scan_sum_t;

  function automatic logic [ADDR_W-1:0] mask_of(input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] m;
    m = '0;
    if (plen >= PLEN_W'(ADDR_W)) begin
      m = '1;
    end else if (plen != '0) begin
      m = {ADDR_W{1'b1}} << (PLEN_W'(ADDR_W) - plen);
    end
    return m;
  endfunction

endpackage

@@ design/iplu_rule_mem.sv @@
// Rule storage: simple dual-port array, one write and one registered read per cycle.
// Depends on iplu_pkg for the rule type.
`timescale 1ns / 1ps

module iplu_rule_mem #(
  parameter int RULE_DEPTH = iplu_pkg::RULE_DEPTH_DEF,
  parameter int AW         = $clog2(RULE_DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  iplu_pkg::rule_t  wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output iplu_pkg::rule_t  rd_data
);
  import iplu_pkg::*;

  rule_t mem_r [RULE_DEPTH];
  rule_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/iplu_scan_unit.sv @@
// Shared compare unit: masks and compares one rule per step, keeps best hits and first duplicate.
// Depends on iplu_pkg for rule, summary types and mask_of.
`timescale 1ns / 1ps

module iplu_scan_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr,
  input  logic                step,
  input  iplu_pkg::rule_t     entry,
  input  logic [31:0]         key_net,
  input  logic [5:0]          key_plen,
  output iplu_pkg::scan_sum_t sum
);
  import iplu_pkg::*;

  logic              ex_found_r, ex_found_nxt;
  logic              gx_found_r, gx_found_nxt;
  logic              dup_found_r, dup_found_nxt;
  logic [PLEN_W-1:0] ex_plen_r, gx_plen_r;
  logic [ACT_W-1:0]  ex_act_r, gx_act_r, dup_act_r;
  logic [TAG_W-1:0]  ex_tag_r, gx_tag_r, dup_tag_r;

  logic              covers;
  logic              cur_found;
  logic [PLEN_W-1:0] cur_plen;
  logic              take;
  logic              dup_take;

  assign covers    = (key_net & mask_of(entry.plen)) == entry.net;
  // Explicit and geo rules each keep their own best; one compare serves both.
  assign cur_found = entry.geo ? gx_found_r : ex_found_r;
  assign cur_plen  = entry.geo ? gx_plen_r : ex_plen_r;
  assign take      = step && covers && (!cur_found || (entry.plen > cur_plen));
  assign dup_take  = step && !dup_found_r && !entry.geo &&
                     (entry.net == key_net) && (entry.plen == key_plen);

  always_comb begin
    ex_found_nxt  = ex_found_r  || (take && !entry.geo);
    gx_found_nxt  = gx_found_r  || (take && entry.geo);
    dup_found_nxt = dup_found_r || dup_take;
    if (clr) begin
      ex_found_nxt  = 1'b0;
      gx_found_nxt  = 1'b0;
      dup_found_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_found_r  <= 1'b0;
      gx_found_r  <= 1'b0;
      dup_found_r <= 1'b0;
    end else begin
      ex_found_r  <= ex_found_nxt;
      gx_found_r  <= gx_found_nxt;
      dup_found_r <= dup_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !entry.geo) begin
      ex_plen_r <= entry.plen;
      ex_act_r  <= entry.act;
      ex_tag_r  <= entry.tag;
    end
    if (take && entry.geo) begin
      gx_plen_r <= entry.plen;
      gx_act_r  <= entry.act;
      gx_tag_r  <= entry.tag;
    end
    if (dup_take) begin
      dup_act_r <= entry.act;
      dup_tag_r <= entry.tag;
    end
  end

  always_comb begin
    sum           = '0;
    sum.dup_found = dup_found_r;
    if (dup_found_r) begin
      sum.dup_act = dup_act_r;
      sum.dup_tag = dup_tag_r;
    end
    if (ex_found_r) begin
      sum.hit_found = 1'b1;
      sum.hit_act   = ex_act_r;
      sum.hit_geo   = 1'b0;
      sum.hit_tag   = ex_tag_r;
    end else if (gx_found_r) begin
      sum.hit_found = 1'b1;
      sum.hit_act   = gx_act_r;
      sum.hit_geo   = 1'b1;
      sum.hit_tag   = gx_tag_r;
    end
  end

endmodule

@@ design/iplu_ctrl.sv @@
// Scan sequencer: walks the stored rules one read per cycle, then closes the item.
// Depends on iplu_pkg for the state, kind and control types.
`timescale 1ns / 1ps

module iplu_ctrl #(
  parameter int RULE_DEPTH = iplu_pkg::RULE_DEPTH_DEF,
  parameter int AW         = $clog2(RULE_DEPTH),
  parameter int CNT_W      = $clog2(RULE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  iplu_pkg::kind_t     kind,
  input  logic [CNT_W-1:0]    count,
  output iplu_pkg::ctl_t      ctl,
  output logic [AW-1:0]       rd_addr
);
  import iplu_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic             more;

  assign more    = idx_r < count;
  assign rd_addr = idx_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (kind == KIND_CLEAR_ALL) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (!more && !pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl      = '0;
    idx_nxt  = idx_r;
    pend_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        ctl.clr = start;
        idx_nxt = '0;
      end
      S_SCAN: begin
        ctl.busy  = 1'b1;
        ctl.issue = more;
        ctl.step  = pend_r;
        pend_nxt  = more;
        if (more) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        ctl.busy   = 1'b1;
        ctl.finish = 1'b1;
      end
      default: begin
        ctl.busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

@@ design/ipv4_prefix_rule_lookup_unit.sv @@
// Top level of the IPv4 prefix rule lookup unit: item latch, rule count, result register.
// Depends on iplu_pkg, iplu_rule_mem, iplu_scan_unit and iplu_ctrl.
`timescale 1ns / 1ps

// An ordered table of up to RULE_DEPTH IPv4 CIDR rules. Raise start with an
// item on in_item; it is taken when busy is low. Each item yields exactly one
// result beat: out_valid is high for one cycle with out_res, and the receiver
// cannot stall it, so capture it in that cycle. Insert, lookup and clear-geo
// walk the stored rules through the single read port of the rule memory, one
// rule per cycle, before the result strobe. Clear-all skips the walk and goes
// straight to the closing state. busy drops in the cycle the result is shown,
// so the next item can be taken then. Lookups prefer explicit rules over
// geo rules, longest prefix first, the earliest rule on a tie. Write
// default_action on the cfg channel only while the block is idle;
// cfg_ready is always high.

module ipv4_prefix_rule_lookup_unit #(
  parameter int RULE_DEPTH = iplu_pkg::RULE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  iplu_pkg::in_item_t in_item,
  output logic               out_valid,
  output iplu_pkg::out_res_t out_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);
  import iplu_pkg::*;

  localparam int AW    = $clog2(RULE_DEPTH);
  localparam int CNT_W = $clog2(RULE_DEPTH + 1);

  ctl_t              ctl;
  logic [AW-1:0]     rd_addr;
  rule_t             rd_data;
  scan_sum_t         sum;

  // Latched item.
  kind_t             kind_r;
  logic [ADDR_W-1:0] key_net_r;
  logic [PLEN_W-1:0] key_plen_r;
  logic [ACT_W-1:0]  act_r;
  logic              geo_r;
  logic [TAG_W-1:0]  tag_r;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  wr_r, wr_nxt;
  logic [ACT_W-1:0]  default_r;
  logic              out_valid_r;
  out_res_t          out_res_r, res_nxt;

  logic              accept;
  logic [PLEN_W-1:0] plen_sat;
  logic              dup_hit;
  logic              full;
  logic              ins_ok;
  logic              keep_step;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  rule_t             wr_data;
  rule_t             new_rule;

  assign accept    = start && !busy;
  assign busy      = ctl.busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Saturate the prefix length at the address width.
  assign plen_sat = (in_item.prefix_len > PLEN_W'(ADDR_W)) ? PLEN_W'(ADDR_W)
                                                          : in_item.prefix_len;

  // Hold the item for the scan; inserts carry their masked network as key.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r     <= in_item.kind;
      key_net_r  <= (in_item.kind == KIND_INSERT) ?
                    (in_item.address & mask_of(plen_sat)) : in_item.address;
      key_plen_r <= plen_sat;
      act_r      <= in_item.rule_action;
      geo_r      <= in_item.from_geo;
      tag_r      <= in_item.tag;
    end
  end

  iplu_ctrl #(
    .RULE_DEPTH (RULE_DEPTH),
    .AW         (AW),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .kind    (in_item.kind),
    .count   (count_r),
    .ctl     (ctl),
    .rd_addr (rd_addr)
  );

  iplu_rule_mem #(
    .RULE_DEPTH (RULE_DEPTH),
    .AW         (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctl.issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  iplu_scan_unit u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (ctl.clr),
    .step     (ctl.step),
    .entry    (rd_data),
    .key_net  (key_net_r),
    .key_plen (key_plen_r),
    .sum      (sum)
  );

  // Insert outcome: duplicate check first, then the full check.
  assign dup_hit = !geo_r && sum.dup_found;
  assign full    = count_r == CNT_W'(RULE_DEPTH);
  assign ins_ok  = (kind_r == KIND_INSERT) && !dup_hit && !full;

  // Clear-geo compaction: move each explicit rule down to the write pointer.
  assign keep_step = ctl.step && (kind_r == KIND_CLEAR_GEO) && !rd_data.geo;

  always_comb begin
    new_rule.net  = key_net_r;
    new_rule.plen = key_plen_r;
    new_rule.act  = act_r;
    new_rule.geo  = geo_r;
    new_rule.tag  = tag_r;
  end

  assign wr_en   = keep_step || (ctl.finish && ins_ok);
  assign wr_addr = ctl.finish ? count_r[AW-1:0] : wr_r[AW-1:0];
  assign wr_data = ctl.finish ? new_rule : rd_data;

  always_comb begin
    wr_nxt = wr_r;
    if (ctl.clr) begin
      wr_nxt = '0;
    end else if (keep_step) begin
      wr_nxt = wr_r + CNT_W'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.finish) begin
      case (kind_r)
        KIND_INSERT: begin
          if (ins_ok) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        KIND_CLEAR_ALL: begin
          count_nxt = '0;
        end
        KIND_CLEAR_GEO: begin
          count_nxt = wr_r;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_comb begin
    res_nxt = '0;
    case (kind_r)
      KIND_INSERT: begin
        if (dup_hit) begin
          res_nxt.status    = (sum.dup_act == act_r) ? STAT_DUP : STAT_CONFLICT;
          res_nxt.match_tag = sum.dup_tag;
        end else if (full) begin
          res_nxt.status = STAT_FULL;
        end
      end
      KIND_LOOKUP: begin
        res_nxt.matched    = sum.hit_found;
        res_nxt.action_out = sum.hit_found ? sum.hit_act : default_r;
        res_nxt.match_geo  = sum.hit_geo;
        res_nxt.match_tag  = sum.hit_tag;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      wr_r        <= '0;
      default_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      wr_r        <= wr_nxt;
      out_valid_r <= ctl.finish;
      if (cfg_valid && cfg_ready) begin
        default_r <= cfg_data;
      end
    end
  end

  // Result payload: load on the closing cycle of an item.
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_res_r <= res_nxt;
    end
  end

  // The rule count never passes the table depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RULE_DEPTH))
    else $error("rule count above table depth");

  // An accepted item keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  // Each result beat follows the closing cycle of an item.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(ctl.finish))
    else $error("result beat without a closing cycle");

  // While busy, the compaction write pointer never passes the rule count.
  assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (wr_r <= count_r))
    else $error("compaction pointer ahead of rule count");

  // Memory writes happen only while an item is in work.
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> busy)
    else $error("rule memory written while idle");

endmodule
